// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the WAV header parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wavhp_pkg.sv =====
// ---------------------------------------------------------------------------
// WAV header parser package
// Types, tags, status codes and sizes shared by the parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  // Default width of the byte and chunk size counters.
  localparam int LENGTH_BITS_DEF = 32;

  // Files shorter than this are reported as too small.
  localparam int MIN_FILE_BYTES = 36;

  // Number of entries in the result queue.
  localparam int RQ_DEPTH = 4;

  // Size of the fixed part of a fmt chunk.
  localparam int FMT_BYTES = 16;

  // Big-endian views of the four character tags.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Audio format code for plain PCM.
  localparam logic [15:0] FMT_PCM = 16'd1;

  // Report status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_BAD_RIFF  = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_NO_FMT    = 3'd4;
  localparam logic [2:0] ST_MALFORMED = 3'd5;

  // Result kinds.
  localparam logic KIND_PCM    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_RSIZE = 3'd1,
    PH_WAVE  = 3'd2,
    PH_HDR   = 3'd3,
    PH_FMT   = 3'd4,
    PH_SKIP  = 3'd5,
    PH_DATA  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pcm_byte;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] pcm_size;
    logic        end_of_run;
  } result_t;

  // Queue write request: first entry, and a second one in the same cycle.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

// ===== src/wav_header_parser.sv =====
// ---------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/WAVE byte stream, passes on PCM data and reports the format.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  ---------------------------------------
//   byte      byte_valid / byte_stall    data_byte, last_byte
//   result    result_valid / result_stall kind, pcm_byte, status, channels,
//                                        sample_rate, bits_per_sample, pcm_size,
//                                        end_of_run
//
// One byte is taken per cycle while byte_stall is low. A byte is held in the
// input register, is parsed there, and its results are written into the result
// queue, whose head drives the result port. The last byte of a file causes one
// extra result (the report), so that byte can put two results into the
// four-entry result queue. byte_stall is raised only while the queue lacks room
// for two more results, which a result side that never stalls never sees.
// Reset clears the parse state and empties the queue; after every report the
// parser returns to its reset state on its own and expects a new RIFF tag.
//
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser
  import wavhp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,

  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             kind,
  output logic [7:0]       pcm_byte,
  output logic [2:0]       status,
  output logic [15:0]      channels,
  output logic [31:0]      sample_rate,
  output logic [15:0]      bits_per_sample,
  output logic [31:0]      pcm_size,
  output logic             end_of_run
);

  // Input register: the item being parsed this cycle.
  logic       r_valid;
  logic [7:0] r_byte;
  logic       r_last;

  logic       fire;
  logic       room;
  push_t      push;
  result_t    res_a;
  result_t    res_b;
  result_t    head;

  // The held item is parsed as soon as the queue can take both of its
  // possible results; otherwise it waits and the byte side is stalled.
  assign fire       = r_valid && room;
  assign byte_stall = r_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!byte_stall) begin
      r_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      r_byte <= data_byte;
      r_last <= last_byte;
    end
  end

  wavhp_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .data_byte(r_byte),
    .last_byte(r_last),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  wavhp_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b),
    .room     (room),
    .not_empty(result_valid),
    .pop      (!result_stall),
    .head     (head)
  );

  // The queue head drives the result port directly; it holds while stalled.
  assign kind            = head.kind;
  assign pcm_byte        = head.pcm_byte;
  assign status          = head.status;
  assign channels        = head.channels;
  assign sample_rate     = head.sample_rate;
  assign bits_per_sample = head.bits_per_sample;
  assign pcm_size        = head.pcm_size;
  assign end_of_run      = head.end_of_run;

endmodule

`default_nettype wire

// ===== src/wavhp_parse.sv =====
// ---------------------------------------------------------------------------
// WAV header parser core
// Parse state, and next-state and result logic for one byte per cycle while fire is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wavhp_parse
  import wavhp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output push_t           push,
  output result_t         res_a,
  output result_t         res_b
);

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  phase_t                 phase, phase_next;
  logic [3:0]             cnt, cnt_next;
  logic [31:0]            tag, tag_next;
  logic [31:0]            clen, clen_next;
  logic [LENGTH_BITS-1:0] left, left_next;
  logic [LENGTH_BITS-1:0] total, total_next;
  logic                   fmt_seen, fmt_seen_next;
  logic                   data_done, data_done_next;
  logic [15:0]            afmt, afmt_next;
  logic [15:0]            chans, chans_next;
  logic [31:0]            rate, rate_next;
  logic [15:0]            bits, bits_next;
  logic [2:0]             err, err_next;
  logic [31:0]            rsize, rsize_next;

  logic [63:0]            clen_wide;
  logic [LENGTH_BITS-1:0] len;
  logic                   pcm_emit;
  logic [2:0]             status;
  result_t                rpt;
  result_t                pcm;

  // Chunk length as seen by the counters, saturated at their maximum. It is
  // only used on the last header byte, which supplies the top length byte.
  assign clen_wide = {32'b0, data_byte, clen[23:0]};
  assign len = (clen_wide > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0] : clen_wide[LENGTH_BITS-1:0];

  // Next state.
  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    tag_next       = tag;
    clen_next      = clen;
    left_next      = left;
    fmt_seen_next  = fmt_seen;
    data_done_next = data_done;
    afmt_next      = afmt;
    chans_next     = chans;
    rate_next      = rate;
    bits_next      = bits;
    err_next       = err;
    rsize_next     = rsize;
    total_next     = (&total) ? total : total + 1'b1;

    unique case (phase)
      PH_RIFF, PH_WAVE: begin
        tag_next = {tag[23:0], data_byte};
        if (cnt >= 4'd3) begin
          cnt_next = '0;
          if (tag_next != ((phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
            err_next   = ST_BAD_RIFF;
            phase_next = PH_DONE;
          end else begin
            phase_next = (phase == PH_RIFF) ? PH_RSIZE : PH_HDR;
          end
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_RSIZE: begin
        if (cnt >= 4'd3) begin
          cnt_next   = '0;
          phase_next = PH_WAVE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_HDR: begin
        if (cnt < 4'd4) begin
          tag_next = {tag[23:0], data_byte};
          if (cnt == 4'd0) begin
            clen_next = '0;
          end
        end else begin
          // Length lanes were cleared at the first tag byte.
          clen_next[{cnt[1:0], 3'b000} +: 8] = data_byte;
        end
        if (cnt >= 4'd7) begin
          cnt_next = '0;
          if (tag_next == TAG_FMT) begin
            if (len < LENGTH_BITS'(FMT_BYTES)) begin
              err_next   = ST_MALFORMED;
              phase_next = PH_DONE;
            end else begin
              left_next  = len - LENGTH_BITS'(FMT_BYTES);
              phase_next = PH_FMT;
            end
          end else if (tag_next == TAG_DATA) begin
            if (!fmt_seen) begin
              err_next   = ST_NO_FMT;
              phase_next = PH_DONE;
            end else begin
              rsize_next = clen_next;
              left_next  = len;
              if (len == '0) begin
                data_done_next = 1'b1;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else begin
            left_next  = len;
            phase_next = (len == '0) ? PH_HDR : PH_SKIP;
          end
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_FMT: begin
        case (cnt) inside
          4'd0:             afmt_next = {8'h00, data_byte};
          4'd1:             afmt_next[15:8] = data_byte;
          4'd2:             chans_next = {8'h00, data_byte};
          4'd3:             chans_next[15:8] = data_byte;
          4'd4:             rate_next = {24'h000000, data_byte};
          4'd5, 4'd6, 4'd7: rate_next[{cnt[1:0], 3'b000} +: 8] = data_byte;
          4'd14:            bits_next = {8'h00, data_byte};
          4'd15:            bits_next[15:8] = data_byte;
          default:          ;
        endcase
        if (cnt == 4'd15) begin
          cnt_next = '0;
          if (afmt_next != FMT_PCM) begin
            err_next   = ST_NOT_PCM;
            phase_next = PH_DONE;
          end else begin
            fmt_seen_next = 1'b1;
            phase_next    = (left == '0) ? PH_HDR : PH_SKIP;
          end
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_SKIP: begin
        if (left != '0) begin
          left_next = left - 1'b1;
        end
        if (left_next == '0) begin
          phase_next = PH_HDR;
        end
      end
      PH_DATA: begin
        if (left != '0) begin
          left_next = left - 1'b1;
        end
        if (left_next == '0) begin
          data_done_next = 1'b1;
          phase_next     = PH_DONE;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  // Results caused by the current byte.
  always_comb begin
    pcm_emit = (phase == PH_DATA);

    if (total_next < LENGTH_BITS'(MIN_FILE_BYTES)) begin
      status = ST_TOO_SMALL;
    end else if (err_next != ST_OK) begin
      status = err_next;
    end else if (data_done_next) begin
      status = ST_OK;
    end else begin
      status = ST_MALFORMED;
    end

    pcm                 = '0;
    pcm.kind            = KIND_PCM;
    pcm.pcm_byte        = data_byte;

    rpt                 = '0;
    rpt.kind            = KIND_REPORT;
    rpt.status          = status;
    rpt.channels        = chans_next;
    rpt.sample_rate     = rate_next;
    rpt.bits_per_sample = bits_next;
    rpt.pcm_size        = rsize_next;
    rpt.end_of_run      = 1'b1;

    res_a       = pcm_emit ? pcm : rpt;
    res_b       = rpt;
    push.first  = fire && (pcm_emit || last_byte);
    push.second = fire && pcm_emit && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      phase     <= PH_RIFF;
      cnt       <= '0;
      tag       <= '0;
      clen      <= '0;
      left      <= '0;
      total     <= '0;
      fmt_seen  <= 1'b0;
      data_done <= 1'b0;
      afmt      <= '0;
      chans     <= '0;
      rate      <= '0;
      bits      <= '0;
      err       <= ST_OK;
      rsize     <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      tag       <= tag_next;
      clen      <= clen_next;
      left      <= left_next;
      total     <= total_next;
      fmt_seen  <= fmt_seen_next;
      data_done <= data_done_next;
      afmt      <= afmt_next;
      chans     <= chans_next;
      rate      <= rate_next;
      bits      <= bits_next;
      err       <= err_next;
      rsize     <= rsize_next;
    end
  end

  `ASSERT_IMPLY(a_err_done, clk, rst, err != ST_OK, phase == PH_DONE, "error without done phase")
  `ASSERT_IMPLY(a_data_done, clk, rst, data_done, phase == PH_DONE, "data done but still parsing")
  `ASSERT_NEXT(a_rearm, clk, rst, fire && last_byte, (phase == PH_RIFF) && (total == '0),
               "parser not rearmed after report")

endmodule

`default_nettype wire

// ===== src/wavhp_resq.sv =====
// ---------------------------------------------------------------------------
// WAV header parser result queue
// Small queue that takes up to two results a cycle and gives one while pop is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wavhp_resq
  import wavhp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  input  wire result_t res_a,
  input  wire result_t res_b,
  output logic         room,
  output logic         not_empty,
  input  wire logic    pop,
  output result_t      head
);

  localparam int PW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  result_t         mem [RQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            do_pop;

  assign room      = (count <= CW'(RQ_DEPTH - 2));
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  assign count_next = count + CW'(push.first) + CW'(push.second) - CW'(do_pop);

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= res_a;
    end
    if (push.second) begin
      mem[wr_ptr + 1'b1] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.first) + PW'(push.second);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(RQ_DEPTH), "result queue count overflow")
  `ASSERT_IMPLY(a_push_room, clk, rst, push.first, room, "push into a queue without room")

endmodule

`default_nettype wire

// ===== tb/sv/tb_wav_header_parser.sv =====
// ---------------------------------------------------------------------------
// WAV header parser testbench
// Streams WAV files into the parser one byte per item and checks each PCM
// byte and each end-of-file report against a cycle-free software parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wav_header_parser;
  import wavhp_pkg::*;

  // Clock, reset and ports. Every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [7:0]  pcm_byte;
  logic [2:0]  status;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [15:0] bits_per_sample;
  logic [31:0] pcm_size;
  logic        end_of_run;

  // Results the software parser has produced and the block has not yet sent.
  result_t     parser_outputs[$];
  result_t     oldest_output;
  int          fail_count = 0;

  // Bytes of the file under construction.
  logic [7:0]  wav_bytes[$];

  // Idle control: percent chance of a sender gap cycle or a receiver stall.
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  // A long receiver hold-off is requested here and counted by the stall process.
  int          hold_request = 0;
  int          hold_count = 0;

  // Software copy of the parse state.
  phase_t      sw_phase;
  logic [4:0]  sw_field_cnt;
  logic [31:0] sw_tag;
  logic [31:0] sw_len;
  logic [31:0] sw_left;
  logic [31:0] sw_seen;
  logic        sw_fmt_seen;
  logic        sw_data_done;
  logic [15:0] sw_fmt_code;
  logic [15:0] sw_channels;
  logic [31:0] sw_rate;
  logic [15:0] sw_bits;
  logic [2:0]  sw_error;
  logic [31:0] sw_data_size;

  wav_header_parser uut (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .pcm_byte        (pcm_byte),
    .status          (status),
    .channels        (channels),
    .sample_rate     (sample_rate),
    .bits_per_sample (bits_per_sample),
    .pcm_size        (pcm_size),
    .end_of_run      (end_of_run)
  );

  always #10 clk = ~clk;

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Software parser
  // ------------------------------------------------------------------------

  // Puts the parse state back to its post-reset values. The block does the
  // same on its own after every report.
  task clear_parse_state();
    sw_phase     = PH_RIFF;
    sw_field_cnt = 5'd0;
    sw_tag       = 32'd0;
    sw_len       = 32'd0;
    sw_left      = 32'd0;
    sw_seen      = 32'd0;
    sw_fmt_seen  = 1'b0;
    sw_data_done = 1'b0;
    sw_fmt_code  = 16'd0;
    sw_channels  = 16'd0;
    sw_rate      = 32'd0;
    sw_bits      = 16'd0;
    sw_error     = ST_OK;
    sw_data_size = 32'd0;
  endtask

  // The first error is latched and every later byte is ignored.
  task stop_with_error(input logic [2:0] code);
    sw_error = code;
    sw_phase = PH_DONE;
  endtask

  // Called once all eight bytes of a chunk header have arrived.
  task close_chunk_header();
    sw_field_cnt = 5'd0;
    if (sw_tag == TAG_FMT) begin
      if (sw_len < FMT_BYTES) begin
        stop_with_error(ST_MALFORMED);
      end else begin
        sw_left  = sw_len - FMT_BYTES;
        sw_phase = PH_FMT;
      end
    end else if (sw_tag == TAG_DATA) begin
      if (!sw_fmt_seen) begin
        stop_with_error(ST_NO_FMT);
      end else begin
        sw_data_size = sw_len;
        sw_left      = sw_len;
        if (sw_len == 32'd0) begin
          // An empty data chunk completes the file at once.
          sw_data_done = 1'b1;
          sw_phase     = PH_DONE;
        end else begin
          sw_phase = PH_DATA;
        end
      end
    end else begin
      // Unknown chunk: skip its body, if it has one.
      sw_left  = sw_len;
      sw_phase = (sw_left == 32'd0) ? PH_HDR : PH_SKIP;
    end
  endtask

  // Parses one accepted byte and queues the results it causes: a PCM byte
  // while inside the data chunk, and the report on the last byte of a file.
  task parse_wav_byte(input logic [7:0] b, input logic last);
    result_t     res;
    logic [4:0]  k;
    logic [31:0] wide_b;
    logic [15:0] half_b;
    k      = sw_field_cnt;
    wide_b = {24'd0, b};
    half_b = {8'd0, b};
    if (sw_seen != 32'hFFFF_FFFF) sw_seen = sw_seen + 32'd1;
    case (sw_phase)
      PH_RIFF, PH_WAVE: begin
        sw_tag = {sw_tag[23:0], b};
        if (k >= 5'd3) begin
          sw_field_cnt = 5'd0;
          if (sw_tag != ((sw_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE))
            stop_with_error(ST_BAD_RIFF);
          else
            sw_phase = (sw_phase == PH_RIFF) ? PH_RSIZE : PH_HDR;
        end else begin
          sw_field_cnt = k + 5'd1;
        end
      end
      PH_RSIZE: begin
        // The RIFF size field is read past and never used.
        if (k >= 5'd3) begin
          sw_field_cnt = 5'd0;
          sw_phase     = PH_WAVE;
        end else begin
          sw_field_cnt = k + 5'd1;
        end
      end
      PH_HDR: begin
        if (k < 5'd4) begin
          sw_tag = {sw_tag[23:0], b};
          if (k == 5'd0) sw_len = 32'd0;
        end else begin
          sw_len = sw_len | (wide_b << (8 * (k - 5'd4)));
        end
        if (k >= 5'd7) close_chunk_header();
        else sw_field_cnt = k + 5'd1;
      end
      PH_FMT: begin
        if (k < 5'd2) begin
          if (k == 5'd0) sw_fmt_code = 16'd0;
          sw_fmt_code = sw_fmt_code | (half_b << (8 * k));
        end else if (k < 5'd4) begin
          if (k == 5'd2) sw_channels = 16'd0;
          sw_channels = sw_channels | (half_b << (8 * (k - 5'd2)));
        end else if (k < 5'd8) begin
          if (k == 5'd4) sw_rate = 32'd0;
          sw_rate = sw_rate | (wide_b << (8 * (k - 5'd4)));
        end else if (k >= 5'd14) begin
          if (k == 5'd14) sw_bits = 16'd0;
          sw_bits = sw_bits | (half_b << (8 * (k - 5'd14)));
        end
        if (k >= 5'd15) begin
          // The format code is judged only once the whole fixed part is in.
          sw_field_cnt = 5'd0;
          if (sw_fmt_code != FMT_PCM) begin
            stop_with_error(ST_NOT_PCM);
          end else begin
            sw_fmt_seen = 1'b1;
            sw_phase    = (sw_left == 32'd0) ? PH_HDR : PH_SKIP;
          end
        end else begin
          sw_field_cnt = k + 5'd1;
        end
      end
      PH_SKIP: begin
        if (sw_left != 32'd0) sw_left = sw_left - 32'd1;
        if (sw_left == 32'd0) sw_phase = PH_HDR;
      end
      PH_DATA: begin
        res          = '0;
        res.kind     = KIND_PCM;
        res.pcm_byte = b;
        parser_outputs.push_back(res);
        if (sw_left != 32'd0) sw_left = sw_left - 32'd1;
        if (sw_left == 32'd0) begin
          sw_data_done = 1'b1;
          sw_phase     = PH_DONE;
        end
      end
      default: sw_phase = PH_DONE;
    endcase

    if (last) begin
      res      = '0;
      res.kind = KIND_REPORT;
      // Too small beats everything, then the first error, then completeness.
      if (sw_seen < MIN_FILE_BYTES) res.status = ST_TOO_SMALL;
      else if (sw_error != ST_OK)   res.status = sw_error;
      else if (sw_data_done)        res.status = ST_OK;
      else                          res.status = ST_MALFORMED;
      res.channels        = sw_channels;
      res.sample_rate     = sw_rate;
      res.bits_per_sample = sw_bits;
      res.pcm_size        = sw_data_size;
      res.end_of_run      = 1'b1;
      parser_outputs.push_back(res);
      clear_parse_state();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result is matched against the oldest outstanding one.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (parser_outputs.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0h status %0h",
                 $time, kind, status);
        fail_count++;
      end else begin
        oldest_output = parser_outputs.pop_front();
        check_field("kind", oldest_output.kind, kind);
        check_field("pcm_byte", oldest_output.pcm_byte, pcm_byte);
        check_field("status", oldest_output.status, status);
        check_field("channels", oldest_output.channels, channels);
        check_field("sample_rate", oldest_output.sample_rate, sample_rate);
        check_field("bits_per_sample", oldest_output.bits_per_sample, bits_per_sample);
        check_field("pcm_size", oldest_output.pcm_size, pcm_size);
        check_field("end_of_run", oldest_output.end_of_run, end_of_run);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count > 0) begin
      result_stall <= 1'b1;
      hold_count = hold_count - 1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Sending
  // ------------------------------------------------------------------------

  // Offers one item, with a random run of idle cycles in front of it, and
  // hands it to the software parser once the block has taken it. Each
  // falling edge carries at most one assignment to byte_valid.
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < tx_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_wav_byte(b, last);
  endtask

  task wait_for_drain();
    while (parser_outputs.size() != 0) @(posedge clk);
  endtask

  // Sends the file held in wav_bytes. When pause_at names a byte index the
  // sender goes quiet before that byte until every result has come out.
  task send_file(input int pause_at);
    for (int i = 0; i < wav_bytes.size(); i++) begin
      if (i == pause_at) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        wait_for_drain();
      end
      send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    end
    wav_bytes.delete();
  endtask

  // ------------------------------------------------------------------------
  // File building
  // ------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Random value with extra weight on all zeros and all ones.
  function automatic logic [31:0] rand_edge32();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Tags go out in reading order, lengths and fields little-endian.
  task add_tag(input logic [31:0] t);
    wav_bytes.push_back(t[31:24]);
    wav_bytes.push_back(t[23:16]);
    wav_bytes.push_back(t[15:8]);
    wav_bytes.push_back(t[7:0]);
  endtask

  task add_le32(input logic [31:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
    wav_bytes.push_back(v[23:16]);
    wav_bytes.push_back(v[31:24]);
  endtask

  task add_le16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endtask

  task add_riff_wave(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
    add_tag(riff_tag);
    add_le32($urandom);
    add_tag(wave_tag);
  endtask

  // A chunk header followed by a given number of random body bytes.
  task add_chunk(input logic [31:0] t, input logic [31:0] len, input int body);
    add_tag(t);
    add_le32(len);
    repeat (body) wav_bytes.push_back(rand_byte());
  endtask

  // A fmt chunk: the 16 fixed bytes always, plus any extra bytes the
  // declared length asks for when that length is modest.
  task add_fmt(input logic [31:0] len, input logic [15:0] code, input logic [15:0] nch,
               input logic [31:0] rate, input logic [15:0] bits);
    add_tag(TAG_FMT);
    add_le32(len);
    add_le16(code);
    add_le16(nch);
    add_le32(rate);
    add_le32($urandom);
    add_le16(16'($urandom));
    add_le16(bits);
    if (len > FMT_BYTES && len < 64) repeat (len - FMT_BYTES) wav_bytes.push_back(rand_byte());
  endtask

  task cut_file(input int n);
    while (wav_bytes.size() > n) void'(wav_bytes.pop_back());
  endtask

  // A plain good file with random format values and a small data chunk.
  task build_good_file(input int data_len);
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'($urandom), $urandom, 16'($urandom));
    add_chunk(TAG_DATA, data_len, data_len);
  endtask

  // Mostly well-formed files with random content; the rest is noise,
  // corrupted tags, odd chunks, truncation and single-bit damage.
  task build_random_file();
    int          r;
    int          p;
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    int          data_body;
    r = $urandom_range(99);
    if (r < 5) begin
      repeat ($urandom_range(1, 60)) wav_bytes.push_back(rand_byte());
    end else begin
      add_riff_wave(($urandom_range(99) < 4) ? TAG_RIFF ^ (32'd1 << $urandom_range(31))
                                             : TAG_RIFF,
                    ($urandom_range(99) < 4) ? TAG_WAVE ^ (32'd1 << $urandom_range(31))
                                             : TAG_WAVE);
      repeat ($urandom_range(0, 2)) begin
        p = $urandom_range(0, 6);
        add_chunk($urandom, p, p);
      end
      if ($urandom_range(99) < 5) add_chunk(TAG_DATA, 32'd2, 2);
      p = $urandom_range(99);
      if (p < 70)      fmt_len = 32'd16;
      else if (p < 90) fmt_len = 32'd16 + $urandom_range(1, 8);
      else if (p < 96) fmt_len = $urandom_range(0, 15);
      else             fmt_len = 32'hFFFF_FFFF;
      add_fmt(fmt_len, ($urandom_range(99) < 90) ? FMT_PCM : 16'(rand_edge32()),
              16'(rand_edge32()), rand_edge32(), 16'(rand_edge32()));
      if ($urandom_range(99) < 10)
        add_fmt(32'd16, FMT_PCM, 16'($urandom), $urandom, 16'($urandom));
      p = $urandom_range(99);
      if (p < 85) begin
        data_len  = $urandom_range(0, 24);
        data_body = data_len;
      end else if (p < 97) begin
        data_len  = $urandom_range(25, 80);
        data_body = data_len;
      end else begin
        data_len  = 32'hFFFF_FFFF;
        data_body = $urandom_range(0, 10);
      end
      add_chunk(TAG_DATA, data_len, data_body);
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 3)) wav_bytes.push_back(rand_byte());
      if ($urandom_range(99) < 15) cut_file($urandom_range(1, wav_bytes.size()));
      if ($urandom_range(99) < 5) begin
        p = $urandom_range(wav_bytes.size() - 1);
        wav_bytes[p] = wav_bytes[p] ^ (8'd1 << $urandom_range(7));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Good files: a small plain file, field extremes, an empty data
  // chunk with trailing bytes, a large fmt, a repeated fmt and skipped chunks.
  task test_good_files();
    build_good_file(4);
    send_file(-1);

    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_chunk(TAG_DATA, 32'd2, 0);
    wav_bytes.push_back(8'hFF);
    wav_bytes.push_back(8'h00);
    send_file(-1);

    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'd0, 32'd0, 16'd0);
    add_chunk(TAG_DATA, 32'd0, 0);
    repeat (3) wav_bytes.push_back(rand_byte());
    send_file(-1);

    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_chunk(32'h4C49_5354, 32'd0, 0);
    add_fmt(32'd20, FMT_PCM, 16'd2, 32'd44100, 16'd16);
    add_chunk(32'h6661_6374, 32'd3, 3);
    add_fmt(32'd16, FMT_PCM, 16'd6, 32'd96000, 16'd24);
    add_chunk(TAG_DATA, 32'd5, 5);
    send_file(-1);
  endtask

  // Header errors, and files too small to judge.
  task test_header_errors();
    add_riff_wave(32'h5249_4658, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'd4, 4);
    send_file(-1);

    add_riff_wave(TAG_RIFF, 32'h5741_5646);
    add_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'd4, 4);
    send_file(-1);

    // A non-PCM format code.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, 16'd3, 16'd2, 32'd48000, 16'd32);
    add_chunk(TAG_DATA, 32'd4, 4);
    send_file(-1);

    // Data chunk before any fmt chunk.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_chunk(TAG_DATA, 32'd4, 4);
    add_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    send_file(-1);

    // A fmt chunk declared shorter than its fixed part.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd14, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'd4, 4);
    send_file(-1);

    // One byte under the minimum size, then exactly the minimum.
    build_good_file(4);
    cut_file(MIN_FILE_BYTES - 1);
    send_file(-1);
    build_good_file(4);
    cut_file(MIN_FILE_BYTES);
    send_file(-1);

    // A one-byte file, and a small file that also has a bad tag.
    wav_bytes.push_back(8'h52);
    send_file(-1);
    add_riff_wave(32'h0000_0000, TAG_WAVE);
    send_file(-1);
  endtask

  // Files that end early or never reach a complete data chunk.
  task test_truncation();
    // Ends partway through the fmt fixed part.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_chunk(32'h4A55_4E4B, 32'd8, 8);
    add_fmt(32'd16, FMT_PCM, 16'd2, 32'd22050, 16'd16);
    cut_file(wav_bytes.size() - 5);
    send_file(-1);

    // Ends inside the data chunk after some PCM bytes.
    build_good_file(10);
    cut_file(wav_bytes.size() - 4);
    send_file(-1);

    // Huge unknown chunk swallows the rest of the file.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(32'h4C49_5354, 32'hFFFF_FFFF, 6);
    send_file(-1);

    // Largest declared data size, cut short.
    add_riff_wave(TAG_RIFF, TAG_WAVE);
    add_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'hFFFF_FFFF, 3);
    send_file(-1);
  endtask

  task test_random_files(input int byte_budget);
    int sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_file();
      sent += wav_bytes.size();
      send_file(-1);
    end
  endtask

  // The receiver holds off while the sender keeps offering a long data
  // chunk, so the result queue fills and the block stalls its input.
  task test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    build_good_file(60);
    hold_request = 200;
    send_file(-1);
    @(negedge clk);
    byte_valid <= 1'b0;
    wait_for_drain();
  endtask

  // The sender stops mid-file until every result has come out, once inside
  // a chunk header and once inside the data chunk.
  task test_drain_pause();
    tx_idle_pct  = 26;
    rx_stall_pct = 26;
    build_good_file(40);
    send_file(40);
    build_good_file(40);
    send_file(55);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    clear_parse_state();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed files with no idling on either side.
    test_good_files();
    test_header_errors();
    test_truncation();

    // Random files under each idle pattern.
    tx_idle_pct = 0;  rx_stall_pct = 0;
    test_random_files(180);
    tx_idle_pct = 60; rx_stall_pct = 0;
    test_random_files(180);
    tx_idle_pct = 0;  rx_stall_pct = 60;
    test_random_files(180);
    tx_idle_pct = 26; rx_stall_pct = 26;
    test_random_files(180);

    test_backpressure();
    test_drain_pause();

    // All items are in: let the block empty and watch for stray results.
    @(negedge clk);
    byte_valid <= 1'b0;
    wait_for_drain();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wavhp_pkg.sv
src/wavhp_parse.sv
src/wavhp_resq.sv
src/wav_header_parser.sv
tb/sv/tb_wav_header_parser.sv
